// ----- rtl/fcb_pkg.sv -----
`default_nettype none
package fcb_pkg;
	localparam int PLANE_COUNT = 6;
	localparam int COORD_WIDTH = 16;
	localparam int NUM_PLANES = 6;
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_MARGIN = 3'd6;
	localparam logic signed [15:0] MARGIN_RESET = -16'sd48;
	localparam logic signed [15:0] CODE_MAX = 16'sh7fff;
	localparam logic signed [15:0] CODE_MIN = -16'sh8000;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef coord_t [2:0] point_t;

	// signed 16-bit slot of a packed word
	function automatic logic signed [15:0] slot16(input logic [63:0] w, input int s);
		slot16 = w[16*s +: 16];
	endfunction

	// saturate a coordinate to the 16-bit code range
	function automatic logic signed [15:0] sat16(input coord_t v);
		logic signed [31:0] e;
		e = 32'(v);
		if (e > 32'(CODE_MAX)) sat16 = CODE_MAX;
		else if (e < 32'(CODE_MIN)) sat16 = CODE_MIN;
		else sat16 = 16'(e);
	endfunction
endpackage
`default_nettype wire

// ----- rtl/fcb_if.sv -----
`default_nettype none
interface fcb_in_if;
	logic valid;
	logic ready;
	logic cmd;
	logic [63:0] matrix_row_x;
	logic [63:0] matrix_row_y;
	logic [63:0] matrix_row_z;
	logic [47:0] box_min;
	logic [47:0] box_max;
	modport source(output valid, cmd, matrix_row_x, matrix_row_y, matrix_row_z, box_min,
		box_max, input ready);
	modport sink(input valid, cmd, matrix_row_x, matrix_row_y, matrix_row_z, box_min,
		box_max, output ready);
endinterface

interface fcb_out_if;
	logic valid;
	logic ready;
	logic culled;
	logic [47:0] bound_min;
	logic [47:0] bound_max;
	modport source(output valid, culled, bound_min, bound_max, input ready);
	modport sink(input valid, culled, bound_min, bound_max, output ready);
endinterface

interface fcb_cfg_if;
	logic valid;
	logic ready;
	logic [2:0] index;
	logic [63:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/fcb_xform_lane.sv -----
`default_nettype none
// transforms one coordinate of one corner from one matrix row: three
// products and the translation, products registered before the sum
module fcb_xform_lane (
	input  wire logic                clk,
	input  wire logic [63:0]         row,
	input  wire logic [47:0]         corner,
	output fcb_pkg::coord_t          coord
);
	import fcb_pkg::*;

	logic signed [31:0] prod_s1 [3];
	logic signed [15:0] trans_s1;
	logic signed [35:0] acc;
	logic signed [35:0] rnd;
	logic signed [35:0] lim;

	// products of linear terms and corner
	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++)
			prod_s1[c] <= slot16(row, c) * slot16({16'd0, corner}, c);
		trans_s1 <= slot16(row, 3);
	end

	// sum, round half up, saturate
	always_comb begin
		lim = (36'sd1 <<< (COORD_WIDTH - 1)) - 36'sd1;
		acc = (36'(trans_s1) <<< 12) + 36'(prod_s1[0]) + 36'(prod_s1[1])
			+ 36'(prod_s1[2]);
		rnd = (acc + 36'sd2048) >>> 12;
		if (rnd > lim) coord = COORD_WIDTH'(lim);
		else if (rnd < -lim - 36'sd1) coord = COORD_WIDTH'(-lim - 36'sd1);
		else coord = COORD_WIDTH'(rnd);
	end
endmodule
`default_nettype wire

// ----- rtl/fcb_plane_lane.sv -----
`default_nettype none
// one plane against both corners: products registered, then sum and compare
module fcb_plane_lane (
	input  wire logic                clk,
	input  wire logic [63:0]         plane,
	input  wire logic signed [15:0]  margin,
	input  fcb_pkg::point_t          pmin,
	input  fcb_pkg::point_t          pmax,
	output logic                     outside
);
	import fcb_pkg::*;

	localparam int PW = COORD_WIDTH + 16;
	logic signed [PW-1:0] pa_s1 [3];
	logic signed [PW-1:0] pb_s1 [3];
	logic signed [PW+3:0] base_s1;
	logic signed [PW+3:0] lim_s1;
	logic signed [PW+3:0] da;
	logic signed [PW+3:0] db;

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			pa_s1[c] <= slot16(plane, c) * pmin[c];
			pb_s1[c] <= slot16(plane, c) * pmax[c];
		end
		base_s1 <= (PW+4)'(slot16(plane, 3)) <<< 14;
		lim_s1 <= (PW+4)'(margin) <<< 14;
	end

	// distance of each corner below the margin
	always_comb begin
		da = base_s1 + (PW+4)'(pa_s1[0]) + (PW+4)'(pa_s1[1]) + (PW+4)'(pa_s1[2]);
		db = base_s1 + (PW+4)'(pb_s1[0]) + (PW+4)'(pb_s1[1]) + (PW+4)'(pb_s1[2]);
		outside = (da < lim_s1) && (db < lim_s1);
	end
endmodule
`default_nettype wire

// ----- rtl/frustum_cull_bounds_unit.sv -----
// frustum_cull_bounds_unit
// Input channel in (valid/ready): one transaction per object test or clear.
// Configuration channel cfg: index 0..5 write the plane words, index 6 the
// cull margin; other indexes are ignored. Always ready.
// Output channel out: one transaction per input with culled and the scene
// bounds after that item.
// Flow: the item is captured in the input registers, the corners pass the
// transform product and corner registers, the six plane lanes register their
// products and compare, then the bounds merge and the result register loads.
// One item is in the datapath at a time; the next item is taken in the cycle
// after the result loads. The step counter of the sequencer waits out the
// pipeline registers of the transform and plane lanes.
// Reset clears the planes to zero, the margin to -3.0 and the bounds to
// their empty values; the output register is emptied.
// When the receiver stalls, the result holds in the output register; one
// further item may be taken and waits at its last step until the register
// frees, and meanwhile no new item is taken.
`default_nettype none
module frustum_cull_bounds_unit (
	input wire logic clk,
	input wire logic arst_n,
	fcb_in_if.sink   in,
	fcb_cfg_if.sink  cfg,
	fcb_out_if.source out
);
	import fcb_pkg::*;

	logic [63:0] plane_q [NUM_PLANES];
	logic signed [15:0] margin_q;
	logic signed [15:0] smin_q [3];
	logic signed [15:0] smax_q [3];
	logic busy_q;
	logic [2:0] step_q;
	logic cmd_q;
	logic [63:0] row_q [3];
	logic [47:0] bmin_q, bmax_q;
	point_t pmin, pmax, pmin_q, pmax_q;
	logic [NUM_PLANES-1:0] outs;
	logic culled;
	logic ovalid_q, oculled_q;
	logic [47:0] omin_q, omax_q;

	assign cfg.ready = 1'b1;
	assign in.ready = !busy_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PLANES; i++) plane_q[i] <= '0;
			margin_q <= MARGIN_RESET;
		end else if (cfg.valid) begin
			if (cfg.index == REG_MARGIN) margin_q <= cfg.data[15:0];
			else if (cfg.index < REG_MARGIN) plane_q[cfg.index] <= cfg.data;
		end
	end

	// input capture
	always_ff @(posedge clk) begin
		if (in.valid && in.ready) begin
			cmd_q <= in.cmd;
			row_q[0] <= in.matrix_row_x;
			row_q[1] <= in.matrix_row_y;
			row_q[2] <= in.matrix_row_z;
			bmin_q <= in.box_min;
			bmax_q <= in.box_max;
		end
	end

	// transform lanes, one per corner coordinate
	for (genvar r = 0; r < 3; r++) begin : g_xf
		fcb_xform_lane u_lo (.clk, .row(row_q[r]), .corner(bmin_q), .coord(pmin[r]));
		fcb_xform_lane u_hi (.clk, .row(row_q[r]), .corner(bmax_q), .coord(pmax[r]));
	end

	always_ff @(posedge clk) begin
		pmin_q <= pmin;
		pmax_q <= pmax;
	end

	// plane lanes
	for (genvar j = 0; j < NUM_PLANES; j++) begin : g_pl
		fcb_plane_lane u_pl (.clk, .plane(plane_q[j]), .margin(margin_q), .pmin(pmin_q),
			.pmax(pmax_q), .outside(outs[j]));
	end

	// merge of lane verdicts over all six planes
	always_comb begin
		culled = 1'b0;
		for (int j = 0; j < PLANE_COUNT; j++) culled = culled | outs[j];
	end

	// sequencer, bounds and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			ovalid_q <= 1'b0;
			for (int c = 0; c < 3; c++) begin
				smin_q[c] <= CODE_MAX;
				smax_q[c] <= CODE_MIN;
			end
		end else begin
			if (out.valid && out.ready) ovalid_q <= 1'b0;
			if (in.valid && in.ready) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q != 3'd4) begin
					step_q <= step_q + 3'd1;
				end else if (!ovalid_q || out.ready) begin
					busy_q <= 1'b0;
					ovalid_q <= 1'b1;
					if (cmd_q) begin
						oculled_q <= 1'b0;
						for (int c = 0; c < 3; c++) begin
							smin_q[c] <= CODE_MAX;
							smax_q[c] <= CODE_MIN;
							omin_q[16*c +: 16] <= CODE_MAX;
							omax_q[16*c +: 16] <= CODE_MIN;
						end
					end else begin
						oculled_q <= culled;
						for (int c = 0; c < 3; c++) begin
							logic signed [15:0] lo, hi, nlo, nhi;
							lo = sat16(pmin_q[c]);
							hi = sat16(pmax_q[c]);
							nlo = (!culled && lo < smin_q[c]) ? lo : smin_q[c];
							nhi = (!culled && hi > smax_q[c]) ? hi : smax_q[c];
							smin_q[c] <= nlo;
							smax_q[c] <= nhi;
							omin_q[16*c +: 16] <= nlo;
							omax_q[16*c +: 16] <= nhi;
						end
					end
				end
			end
		end
	end

	assign out.valid = ovalid_q;
	assign out.culled = oculled_q;
	assign out.bound_min = omin_q;
	assign out.bound_max = omax_q;

	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out.valid && !out.ready) |=> (out.valid && $stable(out.culled)
		&& $stable(out.bound_min) && $stable(out.bound_max)))
		else $error("result changed while stalled");
	a_result_after: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && step_q == 3'd4) |=> ovalid_q) else $error("result not produced");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !in.ready) else $error("accepted while busy");
endmodule
`default_nettype wire

// ----- bench/frustum_cull_bounds_unit_tb.sv -----
`timescale 1ns / 1ps
module frustum_cull_bounds_unit_tb;
	import fcb_pkg::*;

	localparam logic [2:0] REG_LEFT = 3'd0;
	localparam logic [2:0] REG_RIGHT = 3'd1;
	localparam logic [2:0] REG_TOP = 3'd2;
	localparam logic [2:0] REG_BOTTOM = 3'd3;
	localparam logic [2:0] REG_NEAR = 3'd4;
	localparam logic [2:0] REG_FAR = 3'd5;
	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam logic CMD_TEST = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;
	localparam logic [47:0] EMPTY_MIN = {3{16'h7fff}};
	localparam logic [47:0] EMPTY_MAX = {3{16'h8000}};

	typedef struct packed {
		logic cmd;
		logic [63:0] rx;
		logic [63:0] ry;
		logic [63:0] rz;
		logic [47:0] bmin;
		logic [47:0] bmax;
	} obj_item_t;

	typedef struct packed {
		logic culled;
		logic [47:0] lo;
		logic [47:0] hi;
	} cull_result_t;

	typedef struct packed {
		obj_item_t item;
		logic known;
		cull_result_t res;
	} stim_row_t;

	logic clk;
	logic arst_n;

	fcb_in_if in_ch();
	fcb_cfg_if cfg_ch();
	fcb_out_if out_ch();

	frustum_cull_bounds_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in(in_ch.sink),
		.cfg(cfg_ch.sink),
		.out(out_ch.source)
	);

	// predictor state
	logic [63:0] plane_word [6];
	logic signed [15:0] margin;
	logic signed [15:0] keep_min [3];
	logic signed [15:0] keep_max [3];

	cull_result_t pending_results [$];
	stim_row_t directed_rows [$];
	int errors;
	int n_items;
	int n_results;
	int n_culled;
	int n_cfg;
	bit stim_done;
	bit hold_off;

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %h expected %h (result %0d)", what, got, want, n_results);
		errors++;
	endtask

	function automatic logic signed [63:0] sl16(input logic [63:0] w, input int s);
		logic signed [15:0] v;
		v = w[16*s +: 16];
		return 64'(v);
	endfunction

	// world-space corner of one row, rounded half up and saturated
	function automatic logic signed [15:0] world_coord(input logic [63:0] row,
			input logic [47:0] corner);
		logic signed [63:0] acc;
		acc = sl16(row, 3) * 4096;
		for (int c = 0; c < 3; c++) acc += sl16(row, c) * sl16({16'h0, corner}, c);
		acc = (acc + 2048) >>> 12;
		if (acc > 32767) acc = 32767;
		if (acc < -32768) acc = -32768;
		return 16'(acc);
	endfunction

	function automatic bit beyond_plane(input logic [63:0] pl, input logic signed [15:0] p [3]);
		logic signed [63:0] dsum;
		dsum = sl16(pl, 3) * 16384;
		for (int c = 0; c < 3; c++) dsum += sl16(pl, c) * 64'(p[c]);
		return dsum < 64'(margin) * 16384;
	endfunction

	function automatic cull_result_t predict_cull(input obj_item_t it);
		cull_result_t r;
		logic signed [15:0] pa [3];
		logic signed [15:0] pb [3];
		bit cut;
		cut = 0;
		if (it.cmd == CMD_CLEAR) begin
			for (int c = 0; c < 3; c++) begin
				keep_min[c] = CODE_MAX;
				keep_max[c] = CODE_MIN;
			end
		end else begin
			pa[0] = world_coord(it.rx, it.bmin);
			pa[1] = world_coord(it.ry, it.bmin);
			pa[2] = world_coord(it.rz, it.bmin);
			pb[0] = world_coord(it.rx, it.bmax);
			pb[1] = world_coord(it.ry, it.bmax);
			pb[2] = world_coord(it.rz, it.bmax);
			for (int j = 0; j < PLANE_COUNT; j++)
				if (!cut && beyond_plane(plane_word[j], pa) && beyond_plane(plane_word[j], pb))
					cut = 1;
			if (!cut) begin
				for (int c = 0; c < 3; c++) begin
					if (pa[c] < keep_min[c]) keep_min[c] = pa[c];
					if (pb[c] > keep_max[c]) keep_max[c] = pb[c];
				end
			end
		end
		r.culled = cut;
		r.lo = {keep_min[2], keep_min[1], keep_min[0]};
		r.hi = {keep_max[2], keep_max[1], keep_max[0]};
		return r;
	endfunction

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	initial begin
		#100ms;
		$display("frustum_cull_bounds_unit_tb: done, errors");
		$finish;
	end

	// register write, only while the block is idle
	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		if (idx < REG_MARGIN) plane_word[idx] = val;
		else if (idx == REG_MARGIN) margin = val[15:0];
		n_cfg++;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic drain;
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	// one object transaction, with a random gap first unless no_gap is set
	task automatic send_item(input obj_item_t it, input bit known, input cull_result_t want,
			input bit no_gap);
		cull_result_t r;
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 8);
		@(negedge clk);
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.cmd <= it.cmd;
		in_ch.matrix_row_x <= it.rx;
		in_ch.matrix_row_y <= it.ry;
		in_ch.matrix_row_z <= it.rz;
		in_ch.box_min <= it.bmin;
		in_ch.box_max <= it.bmax;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		r = predict_cull(it);
		if (known) r = want;
		pending_results = {pending_results, r};
		n_items++;
	endtask

	function automatic logic [15:0] rnd_q(input int mode);
		case (mode)
			0: return 16'($urandom);
			1: return 16'($urandom_range(0, 1) ? $urandom_range(0, 300) : -$urandom_range(0, 300));
			default: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
		endcase
	endfunction

	// mostly modest scale transforms and boxes so planes split the scene
	function automatic obj_item_t rand_item();
		obj_item_t it;
		int m;
		m = $urandom_range(0, 9);
		it.cmd = ($urandom_range(0, 24) == 0) ? CMD_CLEAR : CMD_TEST;
		if (m < 7) begin
			it.rx = {16'($urandom_range(0, 4000) - 2000), rnd_q(1), rnd_q(1), 16'h1000};
			it.ry = {16'($urandom_range(0, 4000) - 2000), rnd_q(1), 16'h1000, rnd_q(1)};
			it.rz = {16'($urandom_range(0, 4000) - 2000), 16'h1000, rnd_q(1), rnd_q(1)};
			it.bmin = {16'(-$urandom_range(0, 400)), 16'(-$urandom_range(0, 400)),
				16'(-$urandom_range(0, 400))};
			it.bmax = {16'($urandom_range(0, 400)), 16'($urandom_range(0, 400)),
				16'($urandom_range(0, 400))};
		end else begin
			it.rx = {rnd_q(m - 7), rnd_q(0), rnd_q(0), rnd_q(m - 7)};
			it.ry = {$urandom, $urandom};
			it.rz = {$urandom, $urandom};
			it.bmin = {rnd_q(m - 7), 32'($urandom)};
			it.bmax = {rnd_q(0), 32'($urandom)};
		end
		return it;
	endfunction

	// plane facing a random axis with random offset
	function automatic logic [63:0] rand_plane();
		logic [15:0] n [3];
		for (int c = 0; c < 3; c++) n[c] = 16'($urandom_range(0, 2) == 0 ? $urandom_range(0, 32767)
			- 16384 : 0);
		n[$urandom_range(0, 2)] = $urandom_range(0, 1) ? 16'h4000 : 16'hc000;
		return {16'($urandom_range(0, 8000) - 4000), n[2], n[1], n[0]};
	endfunction

	task automatic add_row(input obj_item_t it, input bit known, input logic c,
			input logic [47:0] lo, input logic [47:0] hi);
		stim_row_t s;
		s.item = it;
		s.known = known;
		s.res = '{c, lo, hi};
		directed_rows = {directed_rows, s};
	endtask

	// stimulus
	initial begin
		obj_item_t it;
		cull_result_t none;
		stim_row_t s;
		none = '0;
		errors = 0;
		n_items = 0;
		n_results = 0;
		n_culled = 0;
		n_cfg = 0;
		stim_done = 0;
		for (int j = 0; j < 6; j++) plane_word[j] = '0;
		margin = MARGIN_RESET;
		for (int c = 0; c < 3; c++) begin
			keep_min[c] = CODE_MAX;
			keep_max[c] = CODE_MIN;
		end
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.cmd = CMD_TEST;
		in_ch.matrix_row_x = '0;
		in_ch.matrix_row_y = '0;
		in_ch.matrix_row_z = '0;
		in_ch.box_min = '0;
		in_ch.box_max = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed table: zero planes with margin -3 never cull
		it = '0;
		add_row(it, 1, 1'b0, 48'h0, 48'h0);
		it.cmd = CMD_CLEAR;
		it.rx = '1;
		add_row(it, 1, 1'b0, EMPTY_MIN, EMPTY_MAX);
		it = '0;
		it.rx = {16'h7fff, 48'h0};
		it.ry = {16'h8000, 48'h0};
		it.rz = {16'h7fff, 48'h0};
		add_row(it, 1, 1'b0, {16'h7fff, 16'h8000, 16'h7fff}, {16'h7fff, 16'h8000, 16'h7fff});
		it.rx = {16'h0, 16'h0, 16'h0, 16'h7fff};
		it.ry = {16'h0, 16'h0, 16'h8000, 16'h0};
		it.rz = {16'h0, 16'h8000, 16'h0, 16'h0};
		it.bmin = {3{16'h8000}};
		it.bmax = {3{16'h7fff}};
		add_row(it, 0, 0, 0, 0);
		it.rx = {16'h0010, 16'h0800, 16'hf800, 16'h1000};
		it.ry = {16'hfff0, 16'h1000, 16'h0001, 16'hffff};
		it.rz = {16'h8000, 16'h7fff, 16'h8000, 16'h7fff};
		it.bmin = 48'h0001_ffff_0008;
		it.bmax = 48'hfff8_0007_0001;
		add_row(it, 0, 0, 0, 0);
		it = '0;
		it.cmd = CMD_CLEAR;
		add_row(it, 1, 1'b0, EMPTY_MIN, EMPTY_MAX);
		foreach (directed_rows[k]) begin
			s = directed_rows[k];
			send_item(s.item, s.known, s.res, 0);
		end
		drain();

		// planes set: left x >= 0, far at all-ones then maximum words, margin extremes
		write_reg(REG_LEFT, {16'h0, 16'h0, 16'h0, 16'h4000});
		write_reg(REG_RIGHT, rand_plane());
		write_reg(REG_TOP, rand_plane());
		write_reg(REG_BOTTOM, rand_plane());
		write_reg(REG_NEAR, rand_plane());
		write_reg(REG_FAR, 64'hffff_ffff_ffff_ffff);
		write_reg(REG_MARGIN, 64'h0000_0000_0000_8000);
		write_reg(REG_UNUSED, 64'h0000_0000_0000_7fff);
		for (int k = 0; k < 12; k++) send_item(rand_item(), 0, none, 0);
		drain();
		write_reg(REG_FAR, 64'h7fff_7fff_7fff_7fff);
		write_reg(REG_MARGIN, 64'h0000_0000_0000_7fff);
		for (int k = 0; k < 12; k++) send_item(rand_item(), 0, none, 0);
		drain();

		// random phases with fresh plane settings
		for (int ph = 0; ph < 8; ph++) begin
			for (int j = 0; j < 6; j++) write_reg(3'(j), rand_plane());
			write_reg(REG_MARGIN, {48'h0, 16'($urandom_range(0, 400) - 200)});
			if (ph == 3) write_reg(3'($urandom_range(0, 5)), {$urandom, $urandom});
			if (ph == 2) hold_off = 1;
			for (int k = 0; k < 100; k++) send_item(rand_item(), 0, none, (ph % 3) == 1 &&
				k < 40);
			drain();
		end
		stim_done = 1;
	end

	// receiver with random stalls and one long hold-off
	initial begin
		int gap;
		hold_off = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_ch.ready <= 1'b0;
				repeat (200) @(negedge clk);
				hold_off = 0;
			end
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
			if (gap != 0) begin
				out_ch.ready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
				@(negedge clk);
			end
			out_ch.ready <= 1'b1;
			@(posedge clk);
			while (!out_ch.valid) @(posedge clk);
		end
	end

	// result checker
	always @(posedge clk) begin
		cull_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_results.size() == 0) begin
				report("unexpected result", 64'(out_ch.culled), 64'(0));
			end else begin
				want = pending_results.pop_front();
				if (out_ch.culled !== want.culled) report("culled", 64'(out_ch.culled),
					64'(want.culled));
				if (out_ch.bound_min !== want.lo) report("bound_min", 64'(out_ch.bound_min),
					64'(want.lo));
				if (out_ch.bound_max !== want.hi) report("bound_max", 64'(out_ch.bound_max),
					64'(want.hi));
				n_culled += out_ch.culled;
			end
			n_results++;
		end
	end

	// end of run
	initial begin
		wait (stim_done);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("covered %0d items, %0d results (%0d culled), %0d register writes",
			n_items, n_results, n_culled, n_cfg);
		if (errors == 0 && pending_results.size() == 0)
			$display("frustum_cull_bounds_unit_tb: done, clean");
		else
			$display("frustum_cull_bounds_unit_tb: done, errors");
		$finish;
	end
endmodule
